// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL. They vanish when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rstn, cond, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (expr)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define ASSERT_NEXT(lbl, clk, rstn, cond, expr)
`endif
`endif

// ----- hw/rtl/ftlgc_pkg.sv -----
package ftlgc_pkg;

    localparam int BLOCKS          = 64;
    localparam int PAGES_PER_BLOCK = 32;
    localparam int SECTORS         = 1024;

    localparam int BLK_W  = $clog2(BLOCKS);
    localparam int PG_W   = $clog2(PAGES_PER_BLOCK);
    localparam int FILL_W = $clog2(PAGES_PER_BLOCK + 1);
    localparam int SEC_W  = $clog2(SECTORS);
    localparam int FREE_W = $clog2(BLOCKS + 1);
    localparam int PADDR_W = BLK_W + PG_W;

    // Result kinds carried on the output tuser.
    localparam logic [1:0] RK_READ  = 2'd0;
    localparam logic [1:0] RK_COPY  = 2'd1;
    localparam logic [1:0] RK_PLACE = 2'd2;
    localparam logic [1:0] RK_REFUSE = 2'd3;

    typedef struct packed {
        logic             present;
        logic [BLK_W-1:0] blk;
        logic [PG_W-1:0]  pg;
    } map_word_t;

    typedef struct packed {
        logic             live;
        logic [SEC_W-1:0] owner;
    } page_word_t;

    typedef struct packed {
        logic [FILL_W-1:0] fill;
        logic [FILL_W-1:0] live;
    } blk_word_t;

endpackage

// ----- hw/rtl/page_mapped_ftl_greedy_gc.sv -----
// Page-mapped flash translation layer with greedy garbage collection. Each
// request beat (read or write of a logical sector) is handled by a small
// sequencer that walks three single-port-read memories: the sector map, the
// per-page reverse map with live marks, and the per-block fill and live
// counts. A result beat that waits on a stalled output holds the sequencer
// until it is taken; a write to an already mapped sector first kills the old
// copy. A write that finds only one free block left also scans the BLOCKS
// block counts, skipping the open block and stopping early at a block with
// no live pages, then walks the victim's written pages, reading each page
// and copying the live ones, and erases the victim. Each copy and the final
// placement leave as their own result beats; the input is not ready while a
// request is in progress. After reset a clearing pass over all SECTORS (1024)
// entries empties the sector map before the first request is taken. An
// out-of-range sector gets one refusal beat and changes nothing.
module page_mapped_ftl_greedy_gc (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] sector
    input  logic [0:0]  s_axis_tuser,   // [0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // mapped, src_block, src_page, dst_block,
                                        // dst_page, owner_sector, copy_total, zeros
    output logic [1:0]  m_axis_tuser,   // [1:0] result_kind
    output logic        m_axis_tlast
);

    localparam int BLK_W   = ftlgc_pkg::BLK_W;
    localparam int PG_W    = ftlgc_pkg::PG_W;
    localparam int FILL_W  = ftlgc_pkg::FILL_W;
    localparam int SEC_W   = ftlgc_pkg::SEC_W;
    localparam int FREE_W  = ftlgc_pkg::FREE_W;
    localparam int PADDR_W = ftlgc_pkg::PADDR_W;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_MAP_CHK, S_DECIDE, S_INV_WB, S_FREE_CHK,
        S_SCAN_RD, S_SCAN_CMP, S_COL_RD, S_COL_CHK, S_COL_COPY, S_COL_END,
        S_PLACE_RD, S_PLACE_CHK, S_PLACE, S_REFUSE
    } state_t;

    state_t state_reg, state_next;

    // Request context.
    logic                  kind_reg, kind_next;
    logic [SEC_W-1:0]      sector_reg, sector_next;
    ftlgc_pkg::map_word_t  mword_reg, mword_next;

    // Victim scan and collection.
    logic [BLK_W-1:0]      idx_reg, idx_next;
    logic [FILL_W-1:0]     best_reg, best_next;
    logic                  found_reg, found_next;
    logic [BLK_W-1:0]      victim_reg, victim_next;
    logic [FILL_W-1:0]     vfill_reg, vfill_next;
    logic [FILL_W-1:0]     pg_reg, pg_next;
    logic [SEC_W-1:0]      owner_reg, owner_next;
    logic [FILL_W-1:0]     ofill_reg, ofill_next;
    logic [FILL_W-1:0]     olive_reg, olive_next;

    // Allocation state.
    logic [BLK_W-1:0]      open_reg, open_next;
    logic [BLK_W-1:0]      spare_reg, spare_next;
    logic                  none_reg, none_next;
    logic [FREE_W-1:0]     free_reg, free_next;
    logic [31:0]           copy_reg, copy_next;
    logic [SEC_W-1:0]      clr_reg, clr_next;

    // Output register.
    logic                  ov_reg;
    logic [71:0]           od_reg;
    logic [1:0]            ou_reg;
    logic                  ol_reg;
    logic                  out_free;

    // Result beat being offered by the sequencer this cycle.
    logic                  em_valid;
    logic [1:0]            em_kind;
    logic                  em_mapped;
    logic [BLK_W-1:0]      em_sblk;
    logic [PG_W-1:0]       em_spg;
    logic [BLK_W-1:0]      em_dblk;
    logic [PG_W-1:0]       em_dpg;
    logic [SEC_W-1:0]      em_owner;
    logic                  em_last;
    logic [31:0]           em_copy;

    // Memory ports.
    logic                    map_we;
    logic [SEC_W-1:0]        map_waddr, map_raddr;
    ftlgc_pkg::map_word_t    map_wdata, map_rdata;
    logic                    pg_we;
    logic [PADDR_W-1:0]      pg_waddr, pg_raddr;
    ftlgc_pkg::page_word_t   pg_wdata, pg_rdata;
    logic                    blk_we;
    logic [BLK_W-1:0]        blk_waddr, blk_raddr;
    ftlgc_pkg::blk_word_t    blk_wdata, blk_rraw, blk_rdata;

    // Block counts reset to zero: a block never written reads as empty.
    logic [ftlgc_pkg::BLOCKS-1:0] bvalid_reg;
    logic                         bvq_reg;

    logic                  in_acc;
    logic                  scan_upd;
    logic [FILL_W-1:0]     fill_inc;
    logic [FREE_W-1:0]     free_dec;

    ftlgc_ram #(.DEPTH(ftlgc_pkg::SECTORS), .WIDTH($bits(ftlgc_pkg::map_word_t))) u_map (
        .clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
        .raddr(map_raddr), .rdata(map_rdata)
    );

    ftlgc_ram #(.DEPTH(ftlgc_pkg::BLOCKS * ftlgc_pkg::PAGES_PER_BLOCK),
                .WIDTH($bits(ftlgc_pkg::page_word_t))) u_page (
        .clk(clk), .we(pg_we), .waddr(pg_waddr), .wdata(pg_wdata),
        .raddr(pg_raddr), .rdata(pg_rdata)
    );

    ftlgc_ram #(.DEPTH(ftlgc_pkg::BLOCKS), .WIDTH($bits(ftlgc_pkg::blk_word_t))) u_blk (
        .clk(clk), .we(blk_we), .waddr(blk_waddr), .wdata(blk_wdata),
        .raddr(blk_raddr), .rdata(blk_rraw)
    );

    assign blk_rdata     = bvq_reg ? blk_rraw : '0;
    assign out_free      = !ov_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = od_reg;
    assign m_axis_tuser  = ou_reg;
    assign m_axis_tlast  = ol_reg;

    // A block beats the best so far only with strictly fewer live pages,
    // so the lowest-numbered block wins ties.
    assign scan_upd = (idx_reg != open_reg) && (blk_rdata.live < best_reg);
    assign fill_inc = ofill_reg + FILL_W'(1);
    assign free_dec = (free_reg != '0) ? free_reg - FREE_W'(1) : free_reg;

    always_comb
    begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        sector_next = sector_reg;
        mword_next  = mword_reg;
        idx_next    = idx_reg;
        best_next   = best_reg;
        found_next  = found_reg;
        victim_next = victim_reg;
        vfill_next  = vfill_reg;
        pg_next     = pg_reg;
        owner_next  = owner_reg;
        ofill_next  = ofill_reg;
        olive_next  = olive_reg;
        open_next   = open_reg;
        spare_next  = spare_reg;
        none_next   = none_reg;
        free_next   = free_reg;
        copy_next   = copy_reg;
        clr_next    = clr_reg;

        em_valid  = 1'b0;
        em_kind   = ftlgc_pkg::RK_REFUSE;
        em_mapped = 1'b0;
        em_sblk   = '0;
        em_spg    = '0;
        em_dblk   = '0;
        em_dpg    = '0;
        em_owner  = '0;
        em_last   = 1'b1;
        em_copy   = copy_reg;

        map_we    = 1'b0;
        map_waddr = sector_reg;
        map_wdata = '0;
        map_raddr = sector_reg;
        pg_we     = 1'b0;
        pg_waddr  = {victim_reg, pg_reg[PG_W-1:0]};
        pg_wdata  = '0;
        pg_raddr  = {victim_reg, pg_reg[PG_W-1:0]};
        blk_we    = 1'b0;
        blk_waddr = open_reg;
        blk_wdata = '0;
        blk_raddr = open_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                map_we    = 1'b1;
                map_waddr = clr_reg;
                clr_next  = clr_reg + SEC_W'(1);
                if (clr_reg == SEC_W'(ftlgc_pkg::SECTORS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                map_raddr = s_axis_tdata[SEC_W-1:0];
                if (in_acc)
                begin
                    kind_next   = s_axis_tuser[0];
                    sector_next = s_axis_tdata[SEC_W-1:0];
                    if ({1'b0, s_axis_tdata} >= 17'(ftlgc_pkg::SECTORS))
                    begin
                        state_next = S_REFUSE;
                    end
                    else
                    begin
                        state_next = S_MAP_CHK;
                    end
                end
            end
            S_MAP_CHK:
            begin
                mword_next = map_rdata;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (!kind_reg)
                begin
                    em_valid  = 1'b1;
                    em_kind   = ftlgc_pkg::RK_READ;
                    em_mapped = mword_reg.present;
                    if (mword_reg.present)
                    begin
                        em_dblk  = mword_reg.blk;
                        em_dpg   = mword_reg.pg;
                        em_owner = sector_reg;
                    end
                    if (out_free)
                    begin
                        state_next = S_IDLE;
                    end
                end
                else if (mword_reg.present)
                begin
                    // Kill the old copy; the live count drops next cycle.
                    map_we     = 1'b1;
                    pg_we      = 1'b1;
                    pg_waddr   = {mword_reg.blk, mword_reg.pg};
                    blk_raddr  = mword_reg.blk;
                    state_next = S_INV_WB;
                end
                else
                begin
                    state_next = S_FREE_CHK;
                end
            end
            S_INV_WB:
            begin
                blk_we         = 1'b1;
                blk_waddr      = mword_reg.blk;
                blk_wdata.fill = blk_rdata.fill;
                blk_wdata.live = (blk_rdata.live != '0) ? blk_rdata.live - FILL_W'(1)
                                                         : blk_rdata.live;
                state_next     = S_FREE_CHK;
            end
            S_FREE_CHK:
            begin
                if (free_reg == FREE_W'(1))
                begin
                    idx_next   = '0;
                    best_next  = FILL_W'(ftlgc_pkg::PAGES_PER_BLOCK);
                    found_next = 1'b0;
                    state_next = S_SCAN_RD;
                end
                else
                begin
                    state_next = S_PLACE_RD;
                end
            end
            S_SCAN_RD:
            begin
                blk_raddr  = idx_reg;
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                if (scan_upd)
                begin
                    best_next   = blk_rdata.live;
                    victim_next = idx_reg;
                    vfill_next  = blk_rdata.fill;
                    found_next  = 1'b1;
                end
                if ((scan_upd && blk_rdata.live == '0) ||
                    idx_reg == BLK_W'(ftlgc_pkg::BLOCKS - 1))
                begin
                    pg_next    = '0;
                    state_next = (found_reg || scan_upd) ? S_COL_RD : S_REFUSE;
                end
                else
                begin
                    idx_next   = idx_reg + BLK_W'(1);
                    state_next = S_SCAN_RD;
                end
            end
            S_COL_RD:
            begin
                blk_raddr = open_reg;
                if (pg_reg >= vfill_reg)
                begin
                    state_next = S_COL_END;
                end
                else
                begin
                    state_next = S_COL_CHK;
                end
            end
            S_COL_CHK:
            begin
                if (!pg_rdata.live)
                begin
                    pg_next    = pg_reg + FILL_W'(1);
                    state_next = S_COL_RD;
                end
                else
                begin
                    pg_we = 1'b1;
                    if (blk_rdata.fill >= FILL_W'(ftlgc_pkg::PAGES_PER_BLOCK))
                    begin
                        // No room left: the sector is dropped from the map.
                        map_we     = 1'b1;
                        map_waddr  = pg_rdata.owner;
                        pg_next    = pg_reg + FILL_W'(1);
                        state_next = S_COL_RD;
                    end
                    else
                    begin
                        owner_next = pg_rdata.owner;
                        ofill_next = blk_rdata.fill;
                        olive_next = blk_rdata.live;
                        state_next = S_COL_COPY;
                    end
                end
            end
            S_COL_COPY:
            begin
                em_valid = 1'b1;
                em_kind  = ftlgc_pkg::RK_COPY;
                em_sblk  = victim_reg;
                em_spg   = pg_reg[PG_W-1:0];
                em_dblk  = open_reg;
                em_dpg   = ofill_reg[PG_W-1:0];
                em_owner = owner_reg;
                em_last  = 1'b0;
                em_copy  = (copy_reg == '1) ? copy_reg : copy_reg + 32'd1;
                if (out_free)
                begin
                    pg_we             = 1'b1;
                    pg_waddr          = {open_reg, ofill_reg[PG_W-1:0]};
                    pg_wdata.live     = 1'b1;
                    pg_wdata.owner    = owner_reg;
                    blk_we            = 1'b1;
                    blk_wdata.fill    = fill_inc;
                    blk_wdata.live    = olive_reg + FILL_W'(1);
                    map_we            = 1'b1;
                    map_waddr         = owner_reg;
                    map_wdata.present = 1'b1;
                    map_wdata.blk     = open_reg;
                    map_wdata.pg      = ofill_reg[PG_W-1:0];
                    copy_next         = em_copy;
                    pg_next           = pg_reg + FILL_W'(1);
                    state_next        = S_COL_RD;
                end
            end
            S_COL_END:
            begin
                // Erase the victim; it becomes the spare block.
                blk_we     = 1'b1;
                blk_waddr  = victim_reg;
                free_next  = free_reg + FREE_W'(1);
                spare_next = victim_reg;
                none_next  = 1'b0;
                state_next = S_PLACE_RD;
            end
            S_PLACE_RD:
            begin
                blk_raddr  = open_reg;
                state_next = S_PLACE_CHK;
            end
            S_PLACE_CHK:
            begin
                if (blk_rdata.fill >= FILL_W'(ftlgc_pkg::PAGES_PER_BLOCK))
                begin
                    state_next = S_REFUSE;
                end
                else
                begin
                    ofill_next = blk_rdata.fill;
                    olive_next = blk_rdata.live;
                    state_next = S_PLACE;
                end
            end
            S_PLACE:
            begin
                em_valid = 1'b1;
                em_kind  = ftlgc_pkg::RK_PLACE;
                em_dblk  = open_reg;
                em_dpg   = ofill_reg[PG_W-1:0];
                em_owner = sector_reg;
                if (out_free)
                begin
                    pg_we             = 1'b1;
                    pg_waddr          = {open_reg, ofill_reg[PG_W-1:0]};
                    pg_wdata.live     = 1'b1;
                    pg_wdata.owner    = sector_reg;
                    blk_we            = 1'b1;
                    blk_wdata.fill    = fill_inc;
                    blk_wdata.live    = olive_reg + FILL_W'(1);
                    map_we            = 1'b1;
                    map_wdata.present = 1'b1;
                    map_wdata.blk     = open_reg;
                    map_wdata.pg      = ofill_reg[PG_W-1:0];
                    if (fill_inc == FILL_W'(ftlgc_pkg::PAGES_PER_BLOCK))
                    begin
                        // Open block is full: move to the spare if there is one.
                        free_next = free_dec;
                        if (!none_reg)
                        begin
                            open_next = spare_reg;
                        end
                        if (free_dec == FREE_W'(1))
                        begin
                            none_next = 1'b1;
                        end
                        else
                        begin
                            spare_next = spare_reg + BLK_W'(1);
                            if (spare_reg == BLK_W'(ftlgc_pkg::BLOCKS - 1))
                            begin
                                none_next = 1'b1;
                            end
                        end
                    end
                    state_next = S_IDLE;
                end
            end
            S_REFUSE:
            begin
                em_valid = 1'b1;
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            open_reg   <= '0;
            spare_reg  <= BLK_W'(1);
            none_reg   <= 1'b0;
            free_reg   <= FREE_W'(ftlgc_pkg::BLOCKS);
            copy_reg   <= '0;
            bvalid_reg <= '0;
            ov_reg     <= 1'b0;
            found_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            open_reg  <= open_next;
            spare_reg <= spare_next;
            none_reg  <= none_next;
            free_reg  <= free_next;
            copy_reg  <= copy_next;
            found_reg <= found_next;
            if (blk_we)
            begin
                bvalid_reg[blk_waddr] <= 1'b1;
            end
            if (em_valid && out_free)
            begin
                ov_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        sector_reg <= sector_next;
        mword_reg  <= mword_next;
        idx_reg    <= idx_next;
        best_reg   <= best_next;
        victim_reg <= victim_next;
        vfill_reg  <= vfill_next;
        pg_reg     <= pg_next;
        owner_reg  <= owner_next;
        ofill_reg  <= ofill_next;
        olive_reg  <= olive_next;
        bvq_reg    <= bvalid_reg[blk_raddr];
        if (em_valid && out_free)
        begin
            od_reg <= {7'd0, em_copy, em_owner, em_dpg, em_dblk, em_spg, em_sblk,
                       em_mapped};
            ou_reg <= em_kind;
            ol_reg <= em_last;
        end
    end

`include "assert_macros.svh"

    `ASSERT_ALWAYS(a_free_bounded, clk, rst_n, free_reg <= FREE_W'(ftlgc_pkg::BLOCKS))
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_acc, !s_axis_tready)
    `ASSERT_ALWAYS(a_copy_not_last, clk, rst_n,
                   !(ov_reg && ou_reg == ftlgc_pkg::RK_COPY && ol_reg))

endmodule

// ----- hw/rtl/ftlgc_ram.sv -----
module ftlgc_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
